/* rtl/pdif_pkg.sv */
// Shared types, constants and the multiply-accumulate program of the PPG filter chain.
// Used by the controller, the datapath, the top level and the checker. No dependencies.
`default_nettype none

package pdif_pkg;

  localparam int IN_W = 16;
  localparam int Y_W = 48;
  localparam int VAL_W = 56;
  localparam int PIECE_W = 28;
  localparam int OPA_W = PIECE_W + 1;
  localparam int OPB_W = 38;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W = 92;
  localparam int SMP_MAX_W = 18;
  localparam int COEF_FRAC = 30;
  localparam int GAIN_FRAC = 40;
  localparam int LPIN_SH = 56;
  localparam int HP_TAPS = 5;
  localparam int LP_TAPS = 10;
  localparam int FRAC_BITS_DEF = 24;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int HP_SCALE_STEPS = 2;
  localparam int HP_OUT_STEPS = 2 * (HP_TAPS + 6);
  localparam int LP_SCALE_STEPS = 2;
  localparam int LP_OUT_STEPS = 2 * (LP_TAPS + 11);
  localparam int OFS_IR_OUT = HP_SCALE_STEPS;
  localparam int OFS_RED_SCALE = OFS_IR_OUT + HP_OUT_STEPS;
  localparam int OFS_RED_OUT = OFS_RED_SCALE + HP_SCALE_STEPS;
  localparam int OFS_LP_SCALE = OFS_RED_OUT + HP_OUT_STEPS;
  localparam int OFS_LP_OUT = OFS_LP_SCALE + LP_SCALE_STEPS;
  localparam int NUM_STEPS = OFS_LP_OUT + LP_OUT_STEPS;
  localparam int STEP_W = $clog2(NUM_STEPS + 1);
  localparam int WAIT_CYCLES = 2;
  localparam int WAIT_W = $clog2(WAIT_CYCLES);

  function automatic longint cq(input longint unsigned ip, input longint unsigned fd);
    return longint'((ip << COEF_FRAC) +
                    (((fd << COEF_FRAC) + 64'd5000000000) / 64'd10000000000));
  endfunction

  localparam longint unsigned IG_NUM = (64'd1 << 30) * 64'd1000000000;
  localparam longint unsigned IG_DEN = 64'd1052148876;
  localparam longint unsigned INV_GAIN = ((IG_NUM / IG_DEN) << 10) +
      ((((IG_NUM % IG_DEN) << 10) + IG_DEN / 2) / IG_DEN);
  localparam longint unsigned IGL_NUM = (64'd1 << 46) * 64'd10000;
  localparam longint unsigned IGL_DEN = 64'd5939718719;
  localparam longint unsigned INV_GAINLOW = ((IGL_NUM / IGL_DEN) << 10) +
      ((((IGL_NUM % IGL_DEN) << 10) + IGL_DEN / 2) / IGL_DEN);

  localparam logic signed [OPB_W-1:0] HP_COEF [HP_TAPS] = '{
    OPB_W'(cq(64'd0, 64'd9033282853)), OPB_W'(-cq(64'd4, 64'd6084763585)),
    OPB_W'(cq(64'd9, 64'd4053079892)), OPB_W'(-cq(64'd9, 64'd5984970908)),
    OPB_W'(cq(64'd4, 64'd8983371457))
  };

  localparam logic signed [OPB_W-1:0] LP_COEF [LP_TAPS] = '{
    OPB_W'(-cq(64'd0, 64'd164796305)), OPB_W'(cq(64'd0, 64'd2309193459)),
    OPB_W'(-cq(64'd1, 64'd4737279370)), OPB_W'(cq(64'd5, 64'd6470743441)),
    OPB_W'(-cq(64'd14, 64'd4056874260)), OPB_W'(cq(64'd25, 64'd6017495970)),
    OPB_W'(-cq(64'd32, 64'd1597564880)), OPB_W'(cq(64'd28, 64'd2587879000)),
    OPB_W'(-cq(64'd16, 64'd6721933230)), OPB_W'(cq(64'd5, 64'd9875896298))
  };

  typedef enum logic [2:0] {
    VS_IG, VS_XN, VS_HPIR_X, VS_HPIR_Y, VS_HPRED_X, VS_HPRED_Y, VS_LP_X, VS_LP_Y
  } vsrc_t;

  typedef enum logic [1:0] {BS_CONST, BS_IR, BS_RED} bsel_t;

  typedef enum logic [1:0] {SH_LO, SH_HI, SH_FF_LO, SH_FF_HI} shc_t;

  typedef enum logic [1:0] {RND_HPIN, RND_COEF, RND_LPIN} rnd_t;

  typedef enum logic [1:0] {WB_XN, WB_HPIR, WB_HPRED, WB_LP} wb_t;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_FINISH} state_t;

  typedef struct packed {
    logic first;
    logic last;
    vsrc_t vsrc;
    logic [3:0] vidx;
    logic piece_hi;
    bsel_t bsel;
    logic signed [OPB_W-1:0] bconst;
    shc_t shc;
    rnd_t rnd;
    wb_t wb;
  } step_t;

  typedef struct packed {
    logic load_in;
    logic issue;
    logic load_out;
    step_t step;
  } cmd_t;

  function automatic step_t scale_step(input logic piece_hi, input vsrc_t vsrc,
                                       input logic [3:0] vidx, input bsel_t bsel,
                                       input logic signed [OPB_W-1:0] bconst,
                                       input rnd_t rnd);
    step_t s;
    s.first = !piece_hi;
    s.last = piece_hi;
    s.vsrc = vsrc;
    s.vidx = vidx;
    s.piece_hi = piece_hi;
    s.bsel = bsel;
    s.bconst = bconst;
    s.shc = piece_hi ? SH_HI : SH_LO;
    s.rnd = rnd;
    s.wb = WB_XN;
    return s;
  endfunction

  function automatic step_t hp_out_step(input logic [4:0] k, input logic is_red);
    step_t s;
    logic [3:0] t;
    vsrc_t xsrc;
    t = 4'(k >> 1);
    xsrc = is_red ? VS_HPRED_X : VS_HPIR_X;
    s.first = (k == 5'd0);
    s.last = (k == 5'(HP_OUT_STEPS - 1));
    s.piece_hi = k[0];
    s.bsel = BS_CONST;
    s.rnd = RND_COEF;
    s.wb = is_red ? WB_HPRED : WB_HPIR;
    if (t < 4'd6) begin
      s.shc = k[0] ? SH_FF_HI : SH_FF_LO;
      s.vsrc = xsrc;
      unique case (t)
        4'd0: begin s.vsrc = VS_XN; s.vidx = 4'd0; s.bconst = OPB_W'(1); end
        4'd1: begin s.vidx = 4'd0; s.bconst = OPB_W'(-1); end
        4'd2: begin s.vidx = 4'd1; s.bconst = OPB_W'(5); end
        4'd3: begin s.vidx = 4'd4; s.bconst = OPB_W'(-5); end
        4'd4: begin s.vidx = 4'd3; s.bconst = OPB_W'(10); end
        default: begin s.vidx = 4'd2; s.bconst = OPB_W'(-10); end
      endcase
    end else begin
      s.shc = k[0] ? SH_HI : SH_LO;
      s.vsrc = is_red ? VS_HPRED_Y : VS_HPIR_Y;
      s.vidx = 4'(t - 4'd6);
      s.bconst = HP_COEF[3'(t - 4'd6)];
    end
    return s;
  endfunction

  function automatic step_t lp_out_step(input logic [5:0] k);
    step_t s;
    logic [4:0] t;
    t = 5'(k >> 1);
    s.first = (k == 6'd0);
    s.last = (k == 6'(LP_OUT_STEPS - 1));
    s.piece_hi = k[0];
    s.bsel = BS_CONST;
    s.rnd = RND_COEF;
    s.wb = WB_LP;
    if (t < 5'd11) begin
      s.shc = k[0] ? SH_FF_HI : SH_FF_LO;
      s.vsrc = VS_LP_X;
      unique case (t)
        5'd0: begin s.vidx = 4'd0; s.bconst = OPB_W'(1); end
        5'd1: begin s.vsrc = VS_XN; s.vidx = 4'd0; s.bconst = OPB_W'(1); end
        5'd2: begin s.vidx = 4'd1; s.bconst = OPB_W'(10); end
        5'd3: begin s.vidx = 4'd9; s.bconst = OPB_W'(10); end
        5'd4: begin s.vidx = 4'd2; s.bconst = OPB_W'(45); end
        5'd5: begin s.vidx = 4'd8; s.bconst = OPB_W'(45); end
        5'd6: begin s.vidx = 4'd3; s.bconst = OPB_W'(120); end
        5'd7: begin s.vidx = 4'd7; s.bconst = OPB_W'(120); end
        5'd8: begin s.vidx = 4'd4; s.bconst = OPB_W'(210); end
        5'd9: begin s.vidx = 4'd6; s.bconst = OPB_W'(210); end
        default: begin s.vidx = 4'd5; s.bconst = OPB_W'(252); end
      endcase
    end else begin
      s.shc = k[0] ? SH_HI : SH_LO;
      s.vsrc = VS_LP_Y;
      s.vidx = 4'(t - 5'd11);
      s.bconst = LP_COEF[4'(t - 5'd11)];
    end
    return s;
  endfunction

  function automatic step_t prog_step(input logic [STEP_W-1:0] idx);
    step_t s;
    if (idx < STEP_W'(OFS_IR_OUT)) begin
      s = scale_step(idx[0], VS_IG, 4'd0, BS_IR, OPB_W'(0), RND_HPIN);
    end else if (idx < STEP_W'(OFS_RED_SCALE)) begin
      s = hp_out_step(5'(idx - STEP_W'(OFS_IR_OUT)), 1'b0);
    end else if (idx < STEP_W'(OFS_RED_OUT)) begin
      s = scale_step(idx[0], VS_IG, 4'd0, BS_RED, OPB_W'(0), RND_HPIN);
    end else if (idx < STEP_W'(OFS_LP_SCALE)) begin
      s = hp_out_step(5'(idx - STEP_W'(OFS_RED_OUT)), 1'b1);
    end else if (idx < STEP_W'(OFS_LP_OUT)) begin
      s = scale_step(idx[0], VS_HPIR_Y, 4'(HP_TAPS - 1), BS_CONST,
                     OPB_W'(INV_GAINLOW), RND_LPIN);
    end else begin
      s = lp_out_step(6'(idx - STEP_W'(OFS_LP_OUT)));
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/ppg_dual_iir_filter_chain.sv */
// PPG filter chain: two order-5 high-pass IIR filters and an order-10 low-pass IIR filter.
// Instantiates pdif_ctrl and pdif_datapath; depends on pdif_pkg.
//
// One input transaction carries an infrared and a red photodiode sample. Each sample
// passes through its own DC-removing high-pass filter, and the high-passed infrared
// value then goes through the low-pass filter. One output transaction returns both
// high-passed values and the smoothed infrared value, signed with FRAC_BITS fraction bits.
// Both channels use valid/ready. The block works on one sample pair at a time: in_ready
// is high only while it is idle. Every product goes through a single 29 x 38 multiplier
// and one accumulator, 92 multiply steps per pair, with a drain wait after each of the
// six program sections before the next section starts or the result is loaded.
// in_ready returns in the same cycle as out_valid rises, once the result is loaded.
// The result sits in an output register, so a new pair is accepted and processed while
// the receiver stalls; if the previous result is still not taken when the next one is
// done, the block waits.
// Reset clears all filter delay lines to zero and drops out_valid.
`default_nettype none

module ppg_dual_iir_filter_chain #(
  parameter int FRAC_BITS = pdif_pkg::FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = pdif_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [pdif_pkg::IN_W-1:0]  ir_sample,
  input  wire logic [pdif_pkg::IN_W-1:0]  red_sample,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [pdif_pkg::Y_W-1:0] ir_highpassed,
  output logic signed [pdif_pkg::Y_W-1:0] red_highpassed,
  output logic signed [pdif_pkg::Y_W-1:0] ir_smoothed
);

  pdif_pkg::cmd_t cmd;

  pdif_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  pdif_datapath #(
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .ir_sample      (ir_sample),
    .red_sample     (red_sample),
    .ir_highpassed  (ir_highpassed),
    .red_highpassed (red_highpassed),
    .ir_smoothed    (ir_smoothed)
  );

endmodule

`default_nettype wire

/* rtl/pdif_ctrl.sv */
// Controller state machine of the PPG filter chain: walks the multiply-accumulate program.
// Depends on pdif_pkg; drives pdif_datapath through a command struct.
`default_nettype none

module pdif_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          out_ready,
  output logic               out_valid,
  output pdif_pkg::cmd_t     cmd
);

  pdif_pkg::state_t state, state_next;
  logic [pdif_pkg::STEP_W-1:0] step_idx;
  logic [pdif_pkg::WAIT_W-1:0] wait_cnt;
  pdif_pkg::step_t cur;
  logic out_free;

  assign cur = pdif_pkg::prog_step(step_idx);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      pdif_pkg::ST_IDLE: begin
        if (in_valid) state_next = pdif_pkg::ST_ISSUE;
      end
      pdif_pkg::ST_ISSUE: begin
        if (cur.last) state_next = pdif_pkg::ST_WAIT;
      end
      pdif_pkg::ST_WAIT: begin
        if (wait_cnt == pdif_pkg::WAIT_W'(pdif_pkg::WAIT_CYCLES - 1)) begin
          state_next = (step_idx == pdif_pkg::STEP_W'(pdif_pkg::NUM_STEPS)) ?
                       pdif_pkg::ST_FINISH : pdif_pkg::ST_ISSUE;
        end
      end
      pdif_pkg::ST_FINISH: begin
        if (out_free) state_next = pdif_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = (state == pdif_pkg::ST_IDLE);
    cmd.load_in = (state == pdif_pkg::ST_IDLE) && in_valid;
    cmd.issue = (state == pdif_pkg::ST_ISSUE);
    cmd.load_out = (state == pdif_pkg::ST_FINISH) && out_free;
    cmd.step = cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdif_pkg::ST_IDLE;
      step_idx <= '0;
      wait_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_in) begin
        step_idx <= '0;
      end else if (cmd.issue) begin
        step_idx <= step_idx + 1'b1;
      end
      if (state == pdif_pkg::ST_WAIT) begin
        wait_cnt <= wait_cnt + 1'b1;
      end else begin
        wait_cnt <= '0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/pdif_datapath.sv */
// Datapath of the PPG filter chain: delay lines, one shared multiplier, accumulator, rounding.
// Depends on pdif_pkg; executes the command struct from pdif_ctrl.
`default_nettype none

module pdif_datapath #(
  parameter int FRAC_BITS = pdif_pkg::FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = pdif_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire pdif_pkg::cmd_t                cmd,
  input  wire logic [pdif_pkg::IN_W-1:0]     ir_sample,
  input  wire logic [pdif_pkg::IN_W-1:0]     red_sample,
  output logic signed [pdif_pkg::Y_W-1:0]    ir_highpassed,
  output logic signed [pdif_pkg::Y_W-1:0]    red_highpassed,
  output logic signed [pdif_pkg::Y_W-1:0]    ir_smoothed
);

  localparam int VAL_W = pdif_pkg::VAL_W;
  localparam int Y_W = pdif_pkg::Y_W;
  localparam int ACC_W = pdif_pkg::ACC_W;
  localparam int PW = pdif_pkg::PIECE_W;
  localparam int SMW = pdif_pkg::SMP_MAX_W;
  localparam int HPN = pdif_pkg::HP_TAPS;
  localparam int LPN = pdif_pkg::LP_TAPS;
  localparam int HPIN_SH = pdif_pkg::GAIN_FRAC - FRAC_BITS;
  localparam logic [SMW-1:0] SMP_MASK = SMW'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic signed [ACC_W-1:0] Y_MAX = {{(ACC_W-Y_W+1){1'b0}}, {(Y_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] Y_MIN = ~Y_MAX;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    pdif_pkg::shc_t shc;
    pdif_pkg::rnd_t rnd;
    pdif_pkg::wb_t wb;
  } mac_ctl_t;

  logic [pdif_pkg::IN_W-1:0] ir_q, red_q;
  logic signed [VAL_W-1:0] xn;
  logic signed [VAL_W-1:0] hpir_x [HPN];
  logic signed [Y_W-1:0]   hpir_y [HPN];
  logic signed [VAL_W-1:0] hpred_x [HPN];
  logic signed [Y_W-1:0]   hpred_y [HPN];
  logic signed [VAL_W-1:0] lp_x [LPN];
  logic signed [Y_W-1:0]   lp_y [LPN];

  logic signed [VAL_W-1:0] val;
  logic signed [pdif_pkg::OPA_W-1:0] opa;
  logic signed [pdif_pkg::OPB_W-1:0] opb;
  logic [SMW-1:0] smp_ir, smp_red;
  logic signed [pdif_pkg::PROD_W-1:0] prod_q;
  mac_ctl_t ctl_q;
  logic signed [ACC_W-1:0] prod_ext, addend, acc;
  logic fin_valid;
  pdif_pkg::rnd_t fin_rnd;
  pdif_pkg::wb_t fin_wb;
  logic signed [ACC_W-1:0] half, biased, rounded;
  logic signed [Y_W-1:0] y_sat;

  function automatic logic signed [VAL_W-1:0] sext_y(input logic signed [Y_W-1:0] y);
    return {{(VAL_W-Y_W){y[Y_W-1]}}, y};
  endfunction

  assign smp_ir = SMW'(ir_q) & SMP_MASK;
  assign smp_red = SMW'(red_q) & SMP_MASK;

  always_comb begin
    unique case (cmd.step.vsrc)
      pdif_pkg::VS_IG:      val = VAL_W'(pdif_pkg::INV_GAIN);
      pdif_pkg::VS_XN:      val = xn;
      pdif_pkg::VS_HPIR_X:  val = hpir_x[cmd.step.vidx[2:0]];
      pdif_pkg::VS_HPIR_Y:  val = sext_y(hpir_y[cmd.step.vidx[2:0]]);
      pdif_pkg::VS_HPRED_X: val = hpred_x[cmd.step.vidx[2:0]];
      pdif_pkg::VS_HPRED_Y: val = sext_y(hpred_y[cmd.step.vidx[2:0]]);
      pdif_pkg::VS_LP_X:    val = lp_x[cmd.step.vidx];
      pdif_pkg::VS_LP_Y:    val = sext_y(lp_y[cmd.step.vidx]);
    endcase
    if (cmd.step.piece_hi) begin
      opa = {val[VAL_W-1], val[VAL_W-1:PW]};
    end else begin
      opa = {1'b0, val[PW-1:0]};
    end
    unique case (cmd.step.bsel)
      pdif_pkg::BS_IR:  opb = {{(pdif_pkg::OPB_W-SMW){1'b0}}, smp_ir};
      pdif_pkg::BS_RED: opb = {{(pdif_pkg::OPB_W-SMW){1'b0}}, smp_red};
      default:          opb = cmd.step.bconst;
    endcase
  end

  assign prod_ext = ACC_W'(prod_q);

  always_comb begin
    unique case (ctl_q.shc)
      pdif_pkg::SH_LO:    addend = prod_ext;
      pdif_pkg::SH_HI:    addend = prod_ext <<< PW;
      pdif_pkg::SH_FF_LO: addend = prod_ext <<< pdif_pkg::COEF_FRAC;
      pdif_pkg::SH_FF_HI: addend = prod_ext <<< (pdif_pkg::COEF_FRAC + PW);
    endcase
  end

  always_comb begin
    unique case (fin_rnd)
      pdif_pkg::RND_HPIN: half = ACC_W'(1) <<< (HPIN_SH - 1);
      pdif_pkg::RND_LPIN: half = ACC_W'(1) <<< (pdif_pkg::LPIN_SH - 1);
      default:            half = ACC_W'(1) <<< (pdif_pkg::COEF_FRAC - 1);
    endcase
    biased = acc + half;
    unique case (fin_rnd)
      pdif_pkg::RND_HPIN: rounded = biased >>> HPIN_SH;
      pdif_pkg::RND_LPIN: rounded = biased >>> pdif_pkg::LPIN_SH;
      default:            rounded = biased >>> pdif_pkg::COEF_FRAC;
    endcase
    if (rounded > Y_MAX) begin
      y_sat = Y_MAX[Y_W-1:0];
    end else if (rounded < Y_MIN) begin
      y_sat = Y_MIN[Y_W-1:0];
    end else begin
      y_sat = rounded[Y_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ir_q <= ir_sample;
      red_q <= red_sample;
    end
    if (cmd.issue) begin
      prod_q <= opa * opb;
    end
    if (ctl_q.valid) begin
      acc <= ctl_q.first ? addend : acc + addend;
    end
    if (fin_valid && fin_wb == pdif_pkg::WB_XN) begin
      xn <= rounded[VAL_W-1:0];
    end
    if (cmd.load_out) begin
      ir_highpassed <= hpir_y[HPN-1];
      red_highpassed <= hpred_y[HPN-1];
      ir_smoothed <= lp_y[LPN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
      fin_valid <= 1'b0;
      fin_rnd <= pdif_pkg::RND_COEF;
      fin_wb <= pdif_pkg::WB_XN;
      for (int i = 0; i < HPN; i++) begin
        hpir_x[i] <= '0;
        hpir_y[i] <= '0;
        hpred_x[i] <= '0;
        hpred_y[i] <= '0;
      end
      for (int i = 0; i < LPN; i++) begin
        lp_x[i] <= '0;
        lp_y[i] <= '0;
      end
    end else begin
      ctl_q.valid <= cmd.issue;
      ctl_q.first <= cmd.step.first;
      ctl_q.last <= cmd.step.last;
      ctl_q.shc <= cmd.step.shc;
      ctl_q.rnd <= cmd.step.rnd;
      ctl_q.wb <= cmd.step.wb;
      fin_valid <= ctl_q.valid && ctl_q.last;
      fin_rnd <= ctl_q.rnd;
      fin_wb <= ctl_q.wb;
      if (fin_valid) begin
        unique case (fin_wb)
          pdif_pkg::WB_HPIR: begin
            for (int i = 0; i < HPN - 1; i++) begin
              hpir_x[i] <= hpir_x[i+1];
              hpir_y[i] <= hpir_y[i+1];
            end
            hpir_x[HPN-1] <= xn;
            hpir_y[HPN-1] <= y_sat;
          end
          pdif_pkg::WB_HPRED: begin
            for (int i = 0; i < HPN - 1; i++) begin
              hpred_x[i] <= hpred_x[i+1];
              hpred_y[i] <= hpred_y[i+1];
            end
            hpred_x[HPN-1] <= xn;
            hpred_y[HPN-1] <= y_sat;
          end
          pdif_pkg::WB_LP: begin
            for (int i = 0; i < LPN - 1; i++) begin
              lp_x[i] <= lp_x[i+1];
              lp_y[i] <= lp_y[i+1];
            end
            lp_x[LPN-1] <= xn;
            lp_y[LPN-1] <= y_sat;
          end
          pdif_pkg::WB_XN: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/pdif_checker.sv */
// Port-level checker for the PPG filter chain, bound to the top level.
// Depends on pdif_pkg; sees only the ports of ppg_dual_iir_filter_chain.
`default_nettype none

module pdif_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [pdif_pkg::Y_W-1:0]   ir_highpassed,
  input wire logic [pdif_pkg::Y_W-1:0]   red_highpassed,
  input wire logic [pdif_pkg::Y_W-1:0]   ir_smoothed
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ir_highpassed) &&
                                $stable(red_highpassed) && $stable(ir_smoothed))
    else $error("output changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in progress");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared right after an input transaction");

  a_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result presented while the block is still busy");

endmodule

bind ppg_dual_iir_filter_chain pdif_checker u_pdif_checker (.*);

`default_nettype wire
